// ===== rtl/crp_pkg.sv =====
// Package for the call/return profiler: sizes, action and status codes,
// and the item type passed from front to back. No dependencies.
package crp_pkg;
  localparam int StackDepth   = 256;
  localparam int TableEntries = 256;
  localparam int SpW  = $clog2(StackDepth + 1);
  localparam int SaW  = $clog2(StackDepth);
  localparam int CntW = $clog2(TableEntries + 1);
  localparam int TiW  = $clog2(TableEntries);
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    ActEnter = 2'd0, ActExit = 2'd1, ActRead = 2'd2, ActClear = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StOk = 3'd0, StDisabled = 3'd1, StStackFull = 3'd2, StStackEmpty = 3'd3,
    StTableFull = 3'd4, StBadIndex = 3'd5
  } status_e;

  // Work handed to the back part.
  typedef struct packed {
    logic [1:0]      op;      // ActExit, ActRead, ActClear or none (ActEnter)
    status_e         status;
    logic [63:0]     fn;
    logic [63:0]     elapsed;
    logic [7:0]      ridx;
    logic [SpW-1:0]  depth;
  } job_t;
endpackage

// ===== rtl/crp_front.sv =====
// Front part: holds the shadow stack, classifies each item and computes
// the elapsed time of an exit. Depends on crp_pkg.
module crp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               enable_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [1:0]         action_i,
  input  logic [63:0]        function_address_i,
  input  logic [63:0]       timestamp_i,
  input  logic [7:0]         read_index_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output crp_pkg::job_t      job_o
);
  import crp_pkg::*;

  logic [63:0] fmem [StackDepth];
  logic [63:0] tmem [StackDepth];
  logic [SpW-1:0] sp_q, sp_d;
  logic [63:0] rf_q, rt_q, ts_q;
  logic busy_q;           // exit waiting for stack read
  logic vld_q, vld_d;
  job_t job_q, job_d;
  logic take;

  assign ready_o = !busy_q && (!vld_q || job_ready_i);
  assign take = valid_i && ready_o;
  assign job_valid_o = vld_q;
  assign job_o = job_q;

  always_comb begin
    sp_d  = sp_q;
    vld_d = vld_q && !job_ready_i;
    job_d = job_q;
    if (busy_q) begin
      if (!vld_q || job_ready_i) begin
        vld_d = 1'b1;
        job_d.elapsed = ts_q - rt_q;
        job_d.fn = rf_q;
      end
    end else if (take) begin
      job_d = '0;
      job_d.op = ActEnter;
      job_d.ridx = read_index_i;
      job_d.status = StOk;
      vld_d = 1'b1;
      if (action_i == ActClear) begin
        job_d.op = ActClear;
      end else if (!enable_i) begin
        job_d.status = StDisabled;
      end else if (action_i == ActEnter) begin
        if (sp_q < SpW'(StackDepth)) sp_d = sp_q + 1'b1;
        else job_d.status = StStackFull;
      end else if (action_i == ActExit) begin
        if (sp_q == '0) begin
          job_d.status = StStackEmpty;
        end else begin
          sp_d = sp_q - 1'b1;
          job_d.op = ActExit;
          vld_d = 1'b0;
        end
      end else begin
        job_d.op = ActRead;
      end
      job_d.depth = sp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      busy_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      sp_q <= sp_d;
      vld_q <= vld_d;
      if (take && action_i == ActExit && enable_i && sp_q != '0) busy_q <= 1'b1;
      else if (busy_q && (!vld_q || job_ready_i)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (take) ts_q <= timestamp_i;
    if (take && action_i == ActEnter && enable_i && sp_q < SpW'(StackDepth)) begin
      fmem[sp_q[SaW-1:0]] <= function_address_i;
      tmem[sp_q[SaW-1:0]] <= timestamp_i;
    end
    rf_q <= fmem[sp_d[SaW-1:0]];
    rt_q <= tmem[sp_d[SaW-1:0]];
  end

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(StackDepth)) else $error("stack pointer overflow");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !ready_o) else $error("took item during exit read");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(sp_q)) else $error("stack moved without item");
endmodule

// ===== rtl/crp_queue.sv =====
// Short queue between front and back parts. Depends on crp_pkg.
module crp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wvalid_i,
  output logic          wready_o,
  input  crp_pkg::job_t wdata_i,
  output logic          rvalid_o,
  input  logic          rready_i,
  output crp_pkg::job_t rdata_o
);
  import crp_pkg::*;
  localparam int PW = $clog2(QDepth);
  job_t mem_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0] cnt_q;
  logic wr, rd;

  assign wready_o = cnt_q != (PW+1)'(QDepth);
  assign rvalid_o = cnt_q != '0;
  assign rdata_o  = mem_q[rp_q];
  assign wr = wvalid_i && wready_o;
  assign rd = rvalid_o && rready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end
  always_ff @(posedge clk_i) if (wr) mem_q[wp_q] <= wdata_i;
endmodule

// ===== rtl/crp_back.sv =====
// Back part: table search, update, read and clear; drives the
// result register. Depends on crp_pkg.
module crp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  crp_pkg::job_t job_i,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [2:0]    status_o,
  output logic [63:0]   entry_function_o,
  output logic [63:0]   entry_cycles_o,
  output logic [63:0]   entry_calls_o,
  output logic [8:0]    entry_count_o,
  output logic [8:0]    stack_depth_o
);
  import crp_pkg::*;
  localparam logic [2:0] SIdle = 3'd0, SSearch = 3'd1, SRd = 3'd2,
                         SAdd = 3'd3, SReadOut = 3'd4, SOut = 3'd5;

  logic [63:0] tf [TableEntries];
  logic [63:0] tc [TableEntries];
  logic [63:0] tn [TableEntries];
  logic [2:0] st_q;
  logic [CntW-1:0] used_q, k_q;
  job_t j_q;
  logic [63:0] rf_q, rc_q, rn_q;
  logic hit_q;
  logic full_q;
  logic [2:0]  o_st_q;
  logic [63:0] o_f_q, o_c_q, o_n_q;
  logic [CntW-1:0] o_cnt_q;
  logic [SpW-1:0] o_dep_q;
  logic slot_free;

  assign slot_free  = !full_q || pop_i;
  assign job_ready_o = st_q == SIdle;
  assign empty_o = !full_q;
  assign status_o = o_st_q;
  assign entry_function_o = o_f_q;
  assign entry_cycles_o = o_c_q;
  assign entry_calls_o = o_n_q;
  assign entry_count_o = 9'(o_cnt_q);
  assign stack_depth_o = 9'(o_dep_q);

  // Entries are compared one at a time: read registered, then compare.
  always_ff @(posedge clk_i) begin
    rf_q <= tf[k_q[TiW-1:0]];
    rc_q <= tc[k_q[TiW-1:0]];
    rn_q <= tn[k_q[TiW-1:0]];
    if (st_q == SAdd) begin
      if (hit_q) begin
        tc[k_q[TiW-1:0]] <= rc_q + j_q.elapsed;
        tn[k_q[TiW-1:0]] <= rn_q + 64'd1;
      end else if (used_q < CntW'(TableEntries)) begin
        tf[used_q[TiW-1:0]] <= j_q.fn;
        tc[used_q[TiW-1:0]] <= j_q.elapsed;
        tn[used_q[TiW-1:0]] <= 64'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; used_q <= '0; full_q <= 1'b0; k_q <= '0; hit_q <= 1'b0;
      j_q <= '0;
      o_st_q <= StOk; o_f_q <= '0; o_c_q <= '0; o_n_q <= '0;
      o_cnt_q <= '0; o_dep_q <= '0;
    end else begin
      if (pop_i && full_q && st_q != SOut) full_q <= 1'b0;
      case (st_q)
        SIdle: if (job_valid_i) begin
          j_q <= job_i;
          hit_q <= 1'b0;
          k_q <= (job_i.op == ActRead) ? CntW'(job_i.ridx) : '0;
          case (job_i.op)
            ActExit:  st_q <= SSearch;
            ActRead:  st_q <= SRd;
            ActClear: begin used_q <= '0; st_q <= SOut; end
            default:  st_q <= SOut;
          endcase
        end
        SSearch: begin
          if (k_q >= used_q) st_q <= SAdd;
          else st_q <= SRd;
        end
        SRd: st_q <= SReadOut;
        SReadOut: begin
          if (j_q.op == ActRead) begin
            st_q <= SOut;
          end else if (rf_q == j_q.fn) begin
            hit_q <= 1'b1; st_q <= SAdd;
          end else begin
            k_q <= k_q + 1'b1; st_q <= SSearch;
          end
        end
        SAdd: begin
          if (!hit_q) begin
            if (used_q < CntW'(TableEntries)) used_q <= used_q + 1'b1;
            else j_q.status <= StTableFull;
          end
          st_q <= SOut;
        end
        SOut: if (slot_free) begin
          full_q <= 1'b1;
          o_cnt_q <= used_q;
          o_dep_q <= j_q.depth;
          if (j_q.op == ActRead && j_q.status == StOk && CntW'(j_q.ridx) < used_q) begin
            o_st_q <= j_q.status;
            o_f_q <= rf_q; o_c_q <= rc_q; o_n_q <= rn_q;
          end else begin
            o_st_q <= (j_q.op == ActRead && j_q.status == StOk) ? StBadIndex : j_q.status;
            o_f_q <= '0; o_c_q <= '0; o_n_q <= '0;
          end
          st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(TableEntries)) else $error("table count overflow");
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SOut && slot_free) |=> st_q == SIdle) else $error("result lost");
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> k_q < used_q) else $error("hit beyond table");
endmodule

// ===== rtl/call_return_profiler.sv =====
// Top level of the call/return profiler: front, queue and back part.
// Depends on crp_pkg, crp_front, crp_queue and crp_back.
//
// Each item gives exactly one result. An exit takes a stack read in the front
// and then a table search in the back, which goes through SSearch, SRd and
// SReadOut for each entry compared until a hit or the end of the table. The
// back takes a new item only when it is idle, after the result register of
// the last one is filled; the single-port table search sets the rate. A
// result left unpopped holds the back; the two-entry queue and the front
// register then fill and full rises. Clear is done by resetting the entry
// count; no sweep is needed.
module call_return_profiler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [63:0] function_address_i,
  input  logic [63:0] timestamp_i,
  input  logic [7:0]  read_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [63:0] entry_function_o,
  output logic [63:0] entry_cycles_o,
  output logic [63:0] entry_calls_o,
  output logic [8:0]  entry_count_o,
  output logic [8:0]  stack_depth_o
);
  import crp_pkg::*;
  logic enable_q, rdy, fv, fr, bv, br;
  job_t fj, bj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) enable_q <= 1'b0;
    else if (cfg_we_i) enable_q <= cfg_wdata_i;
  end
  assign full = !rdy;

  crp_front u_front (.clk_i, .rst_ni, .enable_i(enable_q), .valid_i(push),
    .ready_o(rdy), .action_i, .function_address_i, .timestamp_i, .read_index_i,
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj));
  crp_queue u_queue (.clk_i, .rst_ni, .wvalid_i(fv), .wready_o(fr), .wdata_i(fj),
    .rvalid_o(bv), .rready_i(br), .rdata_o(bj));
  crp_back u_back (.clk_i, .rst_ni, .job_valid_i(bv), .job_ready_o(br), .job_i(bj),
    .empty_o(empty), .pop_i(pop), .status_o, .entry_function_o, .entry_cycles_o,
    .entry_calls_o, .entry_count_o, .stack_depth_o);
endmodule

// ===== bench/tb_call_return_profiler.sv =====
`timescale 1ns / 100ps
// Testbench for call_return_profiler: drives enter, exit, read and clear items
// through the queue ports and checks each result against a built-in predictor.
// Depends on crp_pkg and the profiler RTL.
module tb_call_return_profiler;
  import crp_pkg::*;

  localparam int  NumFrames  = 256;
  localparam int  NumEntries = 256;
  localparam int  CycleLimit = 4000000;
  localparam int  SettleCycles = 1000;

  typedef struct {
    status_e     status;
    logic [63:0] fn;
    logic [63:0] cycles;
    logic [63:0] calls;
    logic [8:0]  count;
    logic [8:0]  depth;
  } profile_result_t;

  class profile_scoreboard;
    logic [63:0] frame_fn[NumFrames];
    logic [63:0] frame_time[NumFrames];
    logic [63:0] tab_fn[NumEntries];
    logic [63:0] tab_cycles[NumEntries];
    logic [63:0] tab_calls[NumEntries];
    int          sp;
    int          used;
    bit          enabled;
    profile_result_t awaited[$];
    int          mismatches;

    function void set_enable(bit v);
      enabled = v;
    endfunction

    function void wipe_table();
      for (int k = 0; k < NumEntries; k++) begin
        tab_fn[k] = '0;
        tab_cycles[k] = '0;
        tab_calls[k] = '0;
      end
      used = 0;
    endfunction

    // Predict the result of one accepted item and queue it.
    function void note_item(action_e act, logic [63:0] addr, logic [63:0] ts,
                            logic [7:0] idx);
      profile_result_t r;
      int slot;
      logic [63:0] fn;
      r.status = StOk;
      r.fn = '0;
      r.cycles = '0;
      r.calls = '0;
      if (act == ActClear) begin
        wipe_table();
      end else if (!enabled) begin
        r.status = StDisabled;
      end else if (act == ActEnter) begin
        if (sp < NumFrames) begin
          frame_fn[sp] = addr;
          frame_time[sp] = ts;
          sp++;
        end else begin
          r.status = StStackFull;
        end
      end else if (act == ActExit) begin
        if (sp == 0) begin
          r.status = StStackEmpty;
        end else begin
          sp--;
          fn = frame_fn[sp];
          slot = -1;
          for (int k = 0; k < used; k++)
            if (slot < 0 && tab_fn[k] == fn) slot = k;
          if (slot < 0 && used < NumEntries) begin
            slot = used;
            tab_fn[slot] = fn;
            tab_cycles[slot] = '0;
            tab_calls[slot] = '0;
            used++;
          end
          if (slot < 0) begin
            r.status = StTableFull;
          end else begin
            tab_cycles[slot] += ts - frame_time[sp];
            tab_calls[slot] += 1;
          end
        end
      end else begin
        if (int'(idx) < used) begin
          r.fn = tab_fn[idx];
          r.cycles = tab_cycles[idx];
          r.calls = tab_calls[idx];
        end else begin
          r.status = StBadIndex;
        end
      end
      r.count = 9'(used);
      r.depth = 9'(sp);
      awaited.push_back(r);
    endfunction

    function void check_result(profile_result_t got);
      profile_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing awaited: status %0d", got.status);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.fn !== want.fn || got.cycles !== want.cycles ||
          got.calls !== want.calls || got.count !== want.count || got.depth !== want.depth) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: want st %0d fn %h cyc %h calls %0d cnt %0d dep %0d",
                   want.status, want.fn, want.cycles, want.calls, want.count, want.depth);
          $display("          got  st %0d fn %h cyc %h calls %0d cnt %0d dep %0d",
                   got.status, got.fn, got.cycles, got.calls, got.count, got.depth);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  action_i = '0;
  logic [63:0] function_address_i = '0;
  logic [63:0] timestamp_i = '0;
  logic [7:0]  read_index_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status_o;
  logic [63:0] entry_function_o;
  logic [63:0] entry_cycles_o;
  logic [63:0] entry_calls_o;
  logic [8:0]  entry_count_o;
  logic [8:0]  stack_depth_o;

  profile_scoreboard sb = new();
  int          cycle_count = 0;
  bit          hold_request = 1'b0;
  bit          quiet_sender = 1'b0;
  bit          quiet_receiver = 1'b0;
  logic [63:0] clock_now = '0;
  logic [63:0] addr_pool[24];

  call_return_profiler dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full,
    .action_i, .function_address_i, .timestamp_i, .read_index_i,
    .empty, .pop, .status_o, .entry_function_o, .entry_cycles_o,
    .entry_calls_o, .entry_count_o, .stack_depth_o
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL call_return_profiler");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    profile_result_t got;
    if (rst_ni && pop && !empty) begin
      got.status = status_e'(status_o);
      got.fn = entry_function_o;
      got.cycles = entry_cycles_o;
      got.calls = entry_calls_o;
      got.count = entry_count_o;
      got.depth = stack_depth_o;
      sb.check_result(got);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver: random pop, with one long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        pop = 1'b0;
        for (int c = 0; c < 400; c++) @(negedge clk_i);
        hold_request = 1'b0;
      end
      gap = quiet_receiver ? 0 : pick_gap();
      if (gap > 0) begin
        pop = 1'b0;
        for (int c = 1; c < gap; c++) @(negedge clk_i);
      end else begin
        pop = 1'b1;
      end
    end
  end

  task automatic send_item(action_e act, logic [63:0] addr, logic [63:0] ts,
                           logic [7:0] idx);
    int gap;
    gap = quiet_sender ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      push = 1'b0;
      for (int c = 1; c < gap; c++) @(negedge clk_i);
    end
    @(negedge clk_i);
    push = 1'b1;
    action_i = act;
    function_address_i = addr;
    timestamp_i = ts;
    read_index_i = idx;
    do @(posedge clk_i); while (full);
    sb.note_item(act, addr, ts, idx);
  endtask

  task automatic drain();
    @(negedge clk_i);
    push = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_enable(bit v);
    drain();
    for (int c = 0; c < SettleCycles; c++) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_enable(v);
  endtask

  function automatic logic [63:0] next_stamp();
    if ($urandom_range(0, 19) == 0) clock_now = rand64();
    else clock_now += $urandom_range(1, 5000);
    return clock_now;
  endfunction

  // Mostly nested call/return pairs over a small address pool.
  task automatic random_calls(int n);
    int r;
    logic [63:0] addr;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      addr = ($urandom_range(0, 9) == 0) ? rand64() : addr_pool[$urandom_range(0, 23)];
      if (r < 4) begin
        send_item(action_e'($urandom_range(0, 3)), rand64(), rand64(), 8'($urandom()));
      end else if (r < 6) begin
        send_item(ActClear, rand64(), rand64(), 8'($urandom()));
      end else if (r < 16) begin
        send_item(ActRead, rand64(), rand64(),
                  8'($urandom_range(0, (sb.used + 2 > 255) ? 255 : sb.used + 2)));
      end else if (sb.sp == 0 || (sb.sp < 12 && r < 60)) begin
        send_item(ActEnter, addr, next_stamp(), 8'($urandom()));
      end else begin
        send_item(ActExit, rand64(), next_stamp(), 8'($urandom()));
      end
    end
  endtask

  initial begin
    logic [63:0] ones;
    ones = '1;
    for (int k = 0; k < 24; k++) addr_pool[k] = rand64();
    sb.sp = 0;
    sb.enabled = 1'b0;
    sb.mismatches = 0;
    sb.wipe_table();
    for (int c = 0; c < 4; c++) @(negedge clk_i);
    rst_ni = 1'b1;

    // Refused while disabled; clear still works.
    send_item(ActEnter, 64'h10, 64'h1, 8'd0);
    send_item(ActExit, 64'h10, 64'h2, 8'd0);
    send_item(ActRead, 64'h0, 64'h0, 8'd0);
    send_item(ActClear, 64'h0, 64'h0, 8'd0);
    write_enable(1'b1);
    send_item(ActRead, 64'h0, 64'h0, 8'd0);
    send_item(ActExit, 64'h0, 64'h0, 8'd0);
    send_item(ActEnter, 64'h0, ones, 8'd0);
    send_item(ActExit, ones, 64'd5, 8'd0);        // elapsed wraps
    send_item(ActRead, ones, 64'h0, 8'd0);
    send_item(ActEnter, ones, 64'd0, 8'hff);
    send_item(ActEnter, 64'h0, 64'd100, 8'hff);
    send_item(ActExit, 64'h0, 64'd300, 8'hff);
    send_item(ActExit, 64'h0, ones, 8'hff);
    send_item(ActRead, 64'h0, 64'h0, 8'd1);
    send_item(ActRead, 64'h0, 64'h0, 8'd0);
    send_item(ActRead, 64'h0, 64'h0, 8'd2);
    send_item(ActRead, 64'h0, 64'h0, 8'hff);
    send_item(ActClear, ones, ones, 8'hff);
    send_item(ActRead, 64'h0, 64'h0, 8'd0);

    // Fill the stack past its depth while the receiver holds off.
    hold_request = 1'b1;
    for (int i = 0; i <= NumFrames; i++)
      send_item(ActEnter, addr_pool[$urandom_range(0, 3)], next_stamp(), 8'd0);
    drain();
    quiet_sender = 1'b1;
    quiet_receiver = 1'b1;
    for (int i = 0; i <= NumFrames; i++)
      send_item(ActExit, rand64(), next_stamp(), 8'd0);
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;

    // Fill the table with distinct functions, then overflow it.
    send_item(ActClear, 64'h0, 64'h0, 8'd0);
    for (int i = 0; i <= NumEntries; i++) begin
      send_item(ActEnter, rand64(), next_stamp(), 8'd0);
      send_item(ActExit, rand64(), next_stamp(), 8'd0);
    end
    send_item(ActRead, 64'h0, 64'h0, 8'hff);
    send_item(ActRead, 64'h0, 64'h0, 8'd0);
    send_item(ActClear, 64'h0, 64'h0, 8'd0);

    random_calls(200);
    write_enable(1'b0);
    random_calls(40);
    write_enable(1'b1);
    random_calls(200);
    drain();
    for (int c = 0; c < 200; c++) @(negedge clk_i);
    quiet_sender = 1'b1;
    random_calls(100);
    quiet_sender = 1'b0;
    write_enable(1'b0);
    write_enable(1'b1);
    random_calls(160);

    drain();
    for (int c = 0; c < 100; c++) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("PASS call_return_profiler");
    end else begin
      $display("FAIL call_return_profiler");
    end
    $finish;
  end
endmodule
